FILE: rtl/isotropic_damage_stress_update_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the damage stress update block
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ISOTROPIC_DAMAGE_STRESS_UPDATE_ASSERT_SVH
`define ISOTROPIC_DAMAGE_STRESS_UPDATE_ASSERT_SVH

// same-cycle implication
`define IDSU_ASSERT_NOW(label, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// implication a fixed number of cycles later
`define IDSU_ASSERT_DELAY(label, ant, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> ##dly (cons)) \
        else $error(msg);

`endif

FILE: rtl/idsu_pkg.sv
// ----------------------------------------------------------------------------
// idsu_pkg
// Types, constants and constant tables of the damage stress update block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package idsu_pkg;

    // fixed point constants
    localparam logic [24:0] ONE_Q24     = 25'h1000000;
    localparam logic [25:0] STEP_Q24    = 26'd335544;
    localparam logic [30:0] ONE_Q30     = 31'h40000000;
    localparam logic [29:0] E1_Q30      = 30'd395007542;
    localparam logic [30:0] XT_RESET    = 31'd65536;

    // pipeline geometry
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 32;
    localparam int TAYLOR_N    = 13;
    localparam int RECIP_SHIFT = 38;
    localparam int DMG_LAT     = 6 + SQRT_STEPS + DIV_STEPS + 2 * TAYLOR_N;
    localparam int LANES       = 6;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_LAMBDA = 2'd0,
        CFG_MU     = 2'd1,
        CFG_XT     = 2'd2
    } cfg_idx_t;

    // damage unit result word
    typedef struct packed {
        logic        nl;
        logic [31:0] e;
        logic [24:0] d;
        logic [24:0] keep;
    } dmg_result_t;

    // e^-n in Q1.30 by repeated rounded multiplies, n = 0..31
    typedef logic [30:0] exp_tab_t [32];

    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    tab;
        logic [63:0] p;
        for (int n = 0; n < 32; n++) begin
            p = 64'(ONE_Q30);
            for (int k = 0; k < n; k++) begin
                p = (p * 64'(E1_Q30) + 64'd536870912) >> 30;
            end
            tab[n] = 31'(p);
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_INT_TAB = build_exp_tab();

endpackage

`default_nettype wire

FILE: rtl/idsu_stress_lane.sv
// ----------------------------------------------------------------------------
// idsu_stress_lane
// One stress component of the linear elastic law, two register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idsu_stress_lane
    import idsu_pkg::*;
(
    input  logic               clk,
    input  logic [30:0]        lambda,
    input  logic [30:0]        mu,
    input  logic               normal,
    input  logic signed [31:0] strain,
    input  logic signed [33:0] trace,
    output logic signed [31:0] stress
);

    logic signed [65:0] tr_w;
    logic signed [65:0] lam_w;
    logic signed [65:0] eps_w;
    logic signed [65:0] fac_w;
    logic signed [65:0] prod_tr_reg;
    logic signed [65:0] prod_tr_next;
    logic signed [65:0] prod_e_reg;
    logic signed [65:0] prod_e_next;
    logic signed [66:0] total;
    logic signed [66:0] shifted;
    logic signed [31:0] stress_reg;
    logic signed [31:0] stress_next;

    // products: lambda * trace on normals, 2 mu or mu times strain
    always_comb
    begin
        tr_w  = {{32{trace[33]}}, trace};
        lam_w = {35'd0, lambda};
        eps_w = {{34{strain[31]}}, strain};
        fac_w = normal ? {34'd0, mu, 1'b0} : {35'd0, mu};
        prod_tr_next = normal ? (tr_w * lam_w) : '0;
        prod_e_next  = eps_w * fac_w;
    end

    // floor to Q16.16 and saturate
    always_comb
    begin
        total   = {prod_tr_reg[65], prod_tr_reg} + {prod_e_reg[65], prod_e_reg};
        shifted = total >>> 28;
        if (shifted[66:31] == {36{shifted[66]}})
        begin
            stress_next = shifted[31:0];
        end
        else
        begin
            stress_next = shifted[66] ? 32'sh80000000 : 32'sh7fffffff;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_tr_reg <= prod_tr_next;
        prod_e_reg  <= prod_e_next;
        stress_reg  <= stress_next;
    end

    assign stress = stress_reg;

endmodule

`default_nettype wire

FILE: rtl/idsu_damage.sv
// ----------------------------------------------------------------------------
// idsu_damage
// Merge stage: equivalent strain (sqrt, divide) and damage (exp) pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idsu_damage
    import idsu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] sig_xx,
    input  logic signed [31:0] sig_yy,
    input  logic signed [31:0] sig_zz,
    input  logic [31:0]        e_old,
    input  logic [24:0]        d_old,
    input  logic [30:0]        xt,
    output logic               out_valid,
    output dmg_result_t        result
);

    localparam int ST_EXP = SQRT_STEPS + DIV_STEPS + 4;

    typedef struct packed {
        logic [31:0] e_old;
        logic [24:0] d_old;
        logic [31:0] e;
        logic        nl;
    } meta_t;

    logic        vld_reg  [1:DMG_LAT];
    meta_t       meta_reg [1:DMG_LAT-1];
    meta_t       meta_next[1:DMG_LAT-1];

    logic [31:0] mag      [3];
    logic [63:0] sq_reg   [3];

    logic [63:0] sr_rad_reg  [0:SQRT_STEPS];
    logic [33:0] sr_rem_reg  [0:SQRT_STEPS];
    logic [31:0] sr_root_reg [0:SQRT_STEPS];

    logic [31:0] dv_rem_reg [0:DIV_STEPS];
    logic [31:0] dv_num_reg [0:DIV_STEPS];
    logic [31:0] dv_q_reg   [0:DIV_STEPS];
    logic        dv_sat_reg [0:DIV_STEPS];

    logic [30:0]        tl_term_reg [0:TAYLOR_N];
    logic signed [31:0] tl_sum_reg  [0:TAYLOR_N];
    logic [30:0]        tl_p_reg    [0:TAYLOR_N];
    logic [29:0]        tl_f_reg    [0:TAYLOR_N];
    logic [60:0]        ta_prod_reg [1:TAYLOR_N];
    logic signed [31:0] ta_sum_reg  [1:TAYLOR_N];
    logic [30:0]        ta_p_reg    [1:TAYLOR_N];
    logic [29:0]        ta_f_reg    [1:TAYLOR_N];

    logic [31:0] e_lin;
    logic [31:0] e_val;
    logic        nl_val;
    logic [31:0] x_val;
    logic [30:0] p_val;

    logic [30:0] sum_pos;
    logic [61:0] pr_reg;
    logic [32:0] q_round;
    logic [24:0] exp24;
    logic [24:0] d_raw;
    logic [25:0] cap;
    logic [24:0] d_fin;
    dmg_result_t result_reg;
    dmg_result_t result_next;

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= DMG_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[1] <= in_valid;
            for (int i = 2; i <= DMG_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // history values ride along; e and flag join at the exp stage
    always_comb
    begin
        meta_next[1] = '{e_old: e_old, d_old: d_old, e: 32'd0, nl: 1'b0};
        for (int i = 2; i < DMG_LAT; i++)
        begin
            meta_next[i] = meta_reg[i-1];
            if (i == ST_EXP)
            begin
                meta_next[i].e  = e_val;
                meta_next[i].nl = nl_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 1; i < DMG_LAT; i++)
        begin
            meta_reg[i] <= meta_next[i];
        end
    end

    // squares of the normal stresses
    always_comb
    begin
        mag[0] = sig_xx[31] ? 32'(-sig_xx) : sig_xx;
        mag[1] = sig_yy[31] ? 32'(-sig_yy) : sig_yy;
        mag[2] = sig_zz[31] ? 32'(-sig_zz) : sig_zz;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i] <= 64'(mag[i]) * 64'(mag[i]);
        end
        sr_rad_reg[0]  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        sr_rem_reg[0]  <= '0;
        sr_root_reg[0] <= '0;
    end

    // integer square root, one result bit per stage
    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        logic [35:0] cur;
        logic [35:0] trial;

        always_comb
        begin
            cur   = {sr_rem_reg[j], sr_rad_reg[j][63:62]};
            trial = {2'b00, sr_root_reg[j], 2'b01};
        end

        always_ff @(posedge clk)
        begin
            sr_rad_reg[j+1] <= {sr_rad_reg[j][61:0], 2'b00};
            if (cur >= trial)
            begin
                sr_rem_reg[j+1]  <= 34'(cur - trial);
                sr_root_reg[j+1] <= {sr_root_reg[j][30:0], 1'b1};
            end
            else
            begin
                sr_rem_reg[j+1]  <= cur[33:0];
                sr_root_reg[j+1] <= {sr_root_reg[j][30:0], 1'b0};
            end
        end
    end

    // quotient overflows 32 bits exactly when root >= xt * 256
    always_ff @(posedge clk)
    begin
        dv_rem_reg[0] <= {8'd0, sr_root_reg[SQRT_STEPS][31:8]};
        dv_num_reg[0] <= {sr_root_reg[SQRT_STEPS][7:0], 24'd0};
        dv_q_reg[0]   <= '0;
        dv_sat_reg[0] <= ({7'd0, sr_root_reg[SQRT_STEPS]} >= {xt, 8'd0});
    end

    // restoring divide by tensile strength, one quotient bit per stage
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [32:0] cur;

        assign cur = {dv_rem_reg[j], dv_num_reg[j][31]};

        always_ff @(posedge clk)
        begin
            dv_num_reg[j+1] <= {dv_num_reg[j][30:0], 1'b0};
            dv_sat_reg[j+1] <= dv_sat_reg[j];
            if (cur >= {2'b00, xt})
            begin
                dv_rem_reg[j+1] <= 32'(cur - {2'b00, xt});
                dv_q_reg[j+1]   <= {dv_q_reg[j][30:0], 1'b1};
            end
            else
            begin
                dv_rem_reg[j+1] <= cur[31:0];
                dv_q_reg[j+1]   <= {dv_q_reg[j][30:0], 1'b0};
            end
        end
    end

    // monotone equivalent strain, split exponent into integer and fraction
    always_comb
    begin
        e_lin  = dv_sat_reg[DIV_STEPS] ? 32'hffffffff : dv_q_reg[DIV_STEPS];
        e_val  = (meta_reg[ST_EXP-1].e_old > e_lin) ? meta_reg[ST_EXP-1].e_old : e_lin;
        nl_val = (e_val[31:24] != 8'd0);
        x_val  = e_val - {7'd0, ONE_Q24};
        p_val  = (x_val[31:29] != 3'd0) ? 31'd0 : EXP_INT_TAB[x_val[28:24]];
    end

    always_ff @(posedge clk)
    begin
        tl_term_reg[0] <= ONE_Q30;
        tl_sum_reg[0]  <= $signed({1'b0, ONE_Q30});
        tl_p_reg[0]    <= p_val;
        tl_f_reg[0]    <= {x_val[23:0], 6'd0};
    end

    // Taylor series of exp(-f): multiply stage, then divide by k
    for (genvar k = 1; k <= TAYLOR_N; k++)
    begin : g_taylor
        localparam int Kdiv = k;
        localparam logic [37:0] Recip =
            38'(((64'd1 << RECIP_SHIFT) + 64'(Kdiv) - 64'd1) / 64'(Kdiv));

        logic [29:0] t_val;
        logic [67:0] t_mul;
        logic [30:0] term_new;

        always_ff @(posedge clk)
        begin
            ta_prod_reg[k] <= 61'(tl_term_reg[k-1]) * 61'(tl_f_reg[k-1]);
            ta_sum_reg[k]  <= tl_sum_reg[k-1];
            ta_p_reg[k]    <= tl_p_reg[k-1];
            ta_f_reg[k]    <= tl_f_reg[k-1];
        end

        always_comb
        begin
            t_val = ta_prod_reg[k][59:30];
            t_mul = 68'(t_val) * 68'(Recip);
            if (Kdiv == 1)
            begin
                term_new = {1'b0, t_val};
            end
            else
            begin
                term_new = 31'(t_mul >> RECIP_SHIFT);
            end
        end

        always_ff @(posedge clk)
        begin
            tl_term_reg[k] <= term_new;
            tl_p_reg[k]    <= ta_p_reg[k];
            tl_f_reg[k]    <= ta_f_reg[k];
            if ((Kdiv % 2) == 1)
            begin
                tl_sum_reg[k] <= ta_sum_reg[k] - $signed({1'b0, term_new});
            end
            else
            begin
                tl_sum_reg[k] <= ta_sum_reg[k] + $signed({1'b0, term_new});
            end
        end
    end

    // exp(-n) times exp(-f)
    assign sum_pos = tl_sum_reg[TAYLOR_N][31] ? 31'd0 : tl_sum_reg[TAYLOR_N][30:0];

    always_ff @(posedge clk)
    begin
        pr_reg <= 62'(tl_p_reg[TAYLOR_N]) * 62'(sum_pos);
    end

    // round to Q1.24, damage, step limit, retained fraction
    always_comb
    begin
        q_round = 33'((pr_reg + 62'd536870912) >> 30);
        exp24   = 25'((q_round + 33'd32) >> 6);
        d_raw   = meta_reg[DMG_LAT-1].nl ? (ONE_Q24 - exp24) : 25'd0;
        cap     = {1'b0, meta_reg[DMG_LAT-1].d_old} + STEP_Q24;
        d_fin   = ({1'b0, d_raw} > cap) ? cap[24:0] : d_raw;
        result_next.nl   = meta_reg[DMG_LAT-1].nl;
        result_next.e    = meta_reg[DMG_LAT-1].e;
        result_next.d    = d_fin;
        result_next.keep = ONE_Q24 - d_fin;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid = vld_reg[DMG_LAT];
    assign result    = result_reg;

endmodule

`default_nettype wire

FILE: rtl/idsu_scale_lane.sv
// ----------------------------------------------------------------------------
// idsu_scale_lane
// Scales one stress component by (1 - D), floor, two register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idsu_scale_lane
    import idsu_pkg::*;
(
    input  logic               clk,
    input  logic signed [31:0] sig,
    input  logic [24:0]        keep,
    output logic signed [31:0] stress
);

    logic signed [57:0] sig_w;
    logic signed [57:0] keep_w;
    logic signed [57:0] prod_reg;
    logic signed [57:0] prod_shift;
    logic signed [31:0] stress_reg;

    // keep is at most one, so the product never grows the stress
    always_comb
    begin
        sig_w      = {{26{sig[31]}}, sig};
        keep_w     = {33'd0, keep};
        prod_shift = prod_reg >>> 24;
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= sig_w * keep_w;
        stress_reg <= prod_shift[31:0];
    end

    assign stress = stress_reg;

endmodule

`default_nettype wire

FILE: rtl/isotropic_damage_stress_update.sv
// ----------------------------------------------------------------------------
// isotropic_damage_stress_update
// Scalar damage stress update for one integration point per clock.
//
//   channel   handshake          words
//   input     start / busy       six strains, e history, D history
//   result    done (strobe)      six stresses, e, D, nonlinear flag
//   config    wr_en              wr_index, wr_data
//
// One word is taken every clock; busy stays low.
// The path to a result runs through the 32-stage square root,
// the 32-stage divider and the 13-term exp series in the damage unit.
// Reset clears the valid line and loads the register defaults.
// Results cannot be held off; done marks each for one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isotropic_damage_stress_update
    import idsu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [30:0]        wr_data,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] strain_xx,
    input  logic signed [31:0] strain_yy,
    input  logic signed [31:0] strain_zz,
    input  logic signed [31:0] strain_xy,
    input  logic signed [31:0] strain_yz,
    input  logic signed [31:0] strain_xz,
    input  logic [31:0]        equiv_strain_old,
    input  logic [24:0]        damage_old,
    output logic               done,
    output logic signed [31:0] stress_xx,
    output logic signed [31:0] stress_yy,
    output logic signed [31:0] stress_zz,
    output logic signed [31:0] stress_xy,
    output logic signed [31:0] stress_yz,
    output logic signed [31:0] stress_xz,
    output logic [31:0]        equiv_strain_new,
    output logic [24:0]        damage_new,
    output logic               nonlinear
);

`include "isotropic_damage_stress_update_assert.svh"

    localparam int OUT_LAT = DMG_LAT + 5;

    logic [30:0] lambda_reg;
    logic [30:0] mu_reg;
    logic [30:0] xt_reg;

    logic               accept;
    logic               v_reg [0:2];
    logic signed [31:0] eps_reg [LANES];
    logic signed [33:0] tr_reg;
    logic [31:0]        eold_reg [0:2];
    logic [24:0]        dold_reg [0:2];

    logic signed [31:0] sig_w [LANES];
    logic [LANES-1:0][31:0] sig_dly_reg [1:DMG_LAT];

    logic               dmg_valid;
    dmg_result_t        dmg_res;
    logic               s_v_reg [1:2];
    dmg_result_t        res_d_reg [1:2];
    logic signed [31:0] st_w [LANES];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lambda_reg <= '0;
            mu_reg     <= '0;
            xt_reg     <= XT_RESET;
        end
        else if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_LAMBDA: lambda_reg <= wr_data;
                CFG_MU:     mu_reg     <= wr_data;
                CFG_XT:     xt_reg     <= wr_data;
                default:    ;
            endcase
        end
    end

    // fully pipelined: a word every clock
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // valid line of the front stages and the output stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0]   <= 1'b0;
            v_reg[1]   <= 1'b0;
            v_reg[2]   <= 1'b0;
            s_v_reg[1] <= 1'b0;
            s_v_reg[2] <= 1'b0;
        end
        else
        begin
            v_reg[0]   <= accept;
            v_reg[1]   <= v_reg[0];
            v_reg[2]   <= v_reg[1];
            s_v_reg[1] <= dmg_valid;
            s_v_reg[2] <= s_v_reg[1];
        end
    end

    // input word and trace
    always_ff @(posedge clk)
    begin
        eps_reg[0]  <= strain_xx;
        eps_reg[1]  <= strain_yy;
        eps_reg[2]  <= strain_zz;
        eps_reg[3]  <= strain_xy;
        eps_reg[4]  <= strain_yz;
        eps_reg[5]  <= strain_xz;
        tr_reg      <= 34'(strain_xx) + 34'(strain_yy) + 34'(strain_zz);
        eold_reg[0] <= equiv_strain_old;
        dold_reg[0] <= damage_old;
        eold_reg[1] <= eold_reg[0];
        dold_reg[1] <= dold_reg[0];
        eold_reg[2] <= eold_reg[1];
        dold_reg[2] <= dold_reg[1];
    end

    // elastic stress lanes, normals first
    for (genvar i = 0; i < LANES; i++)
    begin : g_stress
        idsu_stress_lane u_lane (
            .clk    (clk),
            .lambda (lambda_reg),
            .mu     (mu_reg),
            .normal (i < 3),
            .strain (eps_reg[i]),
            .trace  (tr_reg),
            .stress (sig_w[i])
        );
    end

    // merge: equivalent strain and damage
    idsu_damage u_damage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[2]),
        .sig_xx    (sig_w[0]),
        .sig_yy    (sig_w[1]),
        .sig_zz    (sig_w[2]),
        .e_old     (eold_reg[2]),
        .d_old     (dold_reg[2]),
        .xt        (xt_reg),
        .out_valid (dmg_valid),
        .result    (dmg_res)
    );

    // hold the undamaged stresses until the damage is known
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            sig_dly_reg[1][i] <= sig_w[i];
        end
        for (int s = 2; s <= DMG_LAT; s++)
        begin
            sig_dly_reg[s] <= sig_dly_reg[s-1];
        end
        res_d_reg[1] <= dmg_res;
        res_d_reg[2] <= res_d_reg[1];
    end

    // damaged stress lanes
    for (genvar i = 0; i < LANES; i++)
    begin : g_scale
        idsu_scale_lane u_scale (
            .clk    (clk),
            .sig    ($signed(sig_dly_reg[DMG_LAT][i])),
            .keep   (dmg_res.keep),
            .stress (st_w[i])
        );
    end

    assign done             = s_v_reg[2];
    assign stress_xx        = st_w[0];
    assign stress_yy        = st_w[1];
    assign stress_zz        = st_w[2];
    assign stress_xy        = st_w[3];
    assign stress_yz        = st_w[4];
    assign stress_xz        = st_w[5];
    assign equiv_strain_new = res_d_reg[2].e;
    assign damage_new       = res_d_reg[2].d;
    assign nonlinear        = res_d_reg[2].nl;

    // checks
    `IDSU_ASSERT_DELAY(a_latency, accept, OUT_LAT, done, "result word missing after latency")
    `IDSU_ASSERT_NOW(a_dmg_max, done, damage_new <= ONE_Q24, "damage above one")
    `IDSU_ASSERT_NOW(a_dmg_lin, done && !nonlinear, damage_new == 25'd0,
        "damage outside nonlinear range")
    `IDSU_ASSERT_NOW(a_nl_flag, done, nonlinear == (equiv_strain_new[31:24] != 8'd0),
        "nonlinear flag disagrees with equivalent strain")

endmodule

`default_nettype wire
